/* hdl/btm_pkg.sv */
`timescale 1ns / 1ps
package btm_pkg;
    localparam int MAX_LEN    = 64;
    localparam int TABLE_SIZE = MAX_LEN * (MAX_LEN + 1) / 2;
    localparam int TAW        = $clog2(TABLE_SIZE);
    localparam int LW         = $clog2(MAX_LEN);
    localparam int CW         = LW + 1;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [1:0] ADDR_KEEP = 2'd0;
    localparam logic [1:0] ADDR_LEN  = 2'd1;

    typedef enum logic [3:0] {
        S_BUILD_INIT, S_BUILD_RD, S_BUILD_WAIT, S_BUILD_MUL1, S_BUILD_MUL2,
        S_BUILD_WR, S_IDLE, S_MAC_RD, S_MAC_WAIT, S_MAC_MUL, S_MAC_ACC, S_EMIT
    } t_state;

    // triangular index of row i, column j
    function automatic logic [TAW-1:0] tri_idx(input logic [LW-1:0] i, input logic [LW-1:0] j);
        logic [TAW:0] ii;
        ii = {{(TAW+1-LW){1'b0}}, i};
        tri_idx = TAW'(((ii * (ii + 1'b1)) >> 1) + {{(TAW+1-LW){1'b0}}, j});
    endfunction
endpackage

/* hdl/binomial_thinning_matvec_core.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                   | Payload
// -------- | --------------------------- | -----------------------
// input    | i_start & !o_busy           | i_in_value[31:0]
// result   | o_valid strobe, one cycle   | o_out_value, o_out_last
// config   | APB write, pready always 1  | keep_prob, vec_len
// A non-final element is stored in the vector memory. The final element starts
// the product: one shared 32x32 multiplier serves each table term through the
// read, wait, multiply and accumulate steps, and an emit step ends each row.
// Table rebuild (after reset and each keep_prob write) takes two table reads,
// two products and a write per entry, with o_busy held high throughout.
// Reset is synchronous, active low. The receiver cannot stall results.
module binomial_thinning_matvec_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_in_value,
    output logic        o_valid,
    output logic [31:0] o_out_value,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import btm_pkg::*;

    t_state r_state, n_state;
    logic [16:0]   r_keep;
    logic [6:0]    r_len;
    logic [CW-1:0] r_load;
    logic [LW-1:0] r_i, r_j;       // build: row, column; mac: from, to
    logic [LW-1:0] r_n1;           // last index of the vector
    logic [31:0]   r_a;            // first table operand
    logic [31:0]   r_b;            // second table operand
    logic [32:0]   r_acc;
    logic [63:0]   r_prod;
    logic          r_phase;        // build read phase
    logic          r_rebuild;
    logic          r_valid, r_last;
    logic [31:0]   r_out;

    // config decode
    logic wr_en, wr_keep, wr_len;
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign wr_keep = wr_en && paddr[2] == ADDR_KEEP[0];
    assign wr_len  = wr_en && paddr[2] == ADDR_LEN[0];
    always_comb begin
        prdata = (paddr[2] == ADDR_LEN[0]) ? {25'd0, r_len} : {15'd0, r_keep};
    end

    logic [16:0] q, p;
    assign q = (r_keep > ONE_Q16) ? ONE_Q16 : r_keep;
    assign p = ONE_Q16 - q;
    logic [LW-1:0] eff_n1;
    always_comb begin
        if (r_len == 7'd0) eff_n1 = '0;
        else if (r_len > 7'(MAX_LEN)) eff_n1 = LW'(MAX_LEN - 1);
        else eff_n1 = LW'(r_len - 7'd1);
    end

    // memories
    logic           t_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [31:0]    t_wdata, t_rdata, v_rdata;
    logic           v_we;
    btm_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_table (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata));
    btm_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_vec (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(r_load[LW-1:0]), .i_wdata(i_in_value),
        .i_raddr(r_i), .o_rdata(v_rdata));

    logic accept;
    assign o_busy = (r_state != S_IDLE) | r_rebuild;
    assign accept = i_start & ~o_busy;
    assign v_we   = accept && r_load < CW'(MAX_LEN);

    // build helpers: column j of row i-1 exists if j < i, column j-1 if j > 0
    logic has_up, has_left;
    assign has_up   = (r_j < r_i);
    assign has_left = (r_j != '0);

    // shared multiplier operands
    logic [31:0] m_a, m_b;
    always_comb begin
        m_a = t_rdata;
        m_b = 32'd0;
        case (r_state)
            S_BUILD_MUL1: begin m_a = r_b; m_b = has_up ? {15'd0, q} : 32'd0; end
            S_BUILD_MUL2: begin m_a = r_a; m_b = has_left ? {15'd0, p} : 32'd0; end
            S_MAC_MUL:    m_b = v_rdata;
            default:      m_b = 32'd0;
        endcase
    end
    logic [63:0] mul;
    assign mul = m_a * m_b;

    logic [32:0] sum_b, sat_sum;
    assign sum_b   = r_acc + {1'b0, r_prod[47:16]} + {33'd0};
    assign sat_sum = sum_b[32] ? 33'h0_FFFF_FFFF : sum_b;
    logic [32:0] sum_m;
    assign sum_m = r_acc + {1'b0, r_prod[62:31]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BUILD_INIT: n_state = S_BUILD_RD;
            S_BUILD_RD:   n_state = S_BUILD_WAIT;
            S_BUILD_WAIT: n_state = r_phase ? S_BUILD_MUL2 : S_BUILD_RD;
            S_BUILD_MUL1: n_state = S_BUILD_WR;
            S_BUILD_MUL2: n_state = S_BUILD_MUL1;
            S_BUILD_WR:   n_state = (r_i == LW'(MAX_LEN - 1) && r_j == r_i) ? S_IDLE
                                                                           : S_BUILD_RD;
            S_IDLE: begin
                if (r_rebuild) n_state = S_BUILD_INIT;
                else if (accept && r_load >= CW'(eff_n1)) n_state = S_MAC_RD;
            end
            S_MAC_RD:     n_state = S_MAC_WAIT;
            S_MAC_WAIT:   n_state = S_MAC_MUL;
            S_MAC_MUL:    n_state = S_MAC_ACC;
            S_MAC_ACC:    n_state = (r_i == r_n1) ? S_EMIT : S_MAC_RD;
            S_EMIT:       n_state = (r_j == r_n1) ? S_IDLE : S_MAC_RD;
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath control outputs
    always_comb begin
        t_we    = 1'b0;
        t_waddr = tri_idx(r_i, r_j);
        t_wdata = sat_sum[31:0];
        t_raddr = tri_idx(r_i, r_j);
        case (r_state)
            S_BUILD_INIT: begin t_we = 1'b1; t_waddr = '0; t_wdata = ONE_Q31; end
            S_BUILD_RD: begin
                // first read column j-1, then column j of row i-1
                if (!r_phase) t_raddr = tri_idx(r_i - 1'b1, has_left ? r_j - 1'b1 : '0);
                else          t_raddr = tri_idx(r_i - 1'b1, has_up ? r_j : '0);
            end
            S_BUILD_WR: t_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_BUILD_INIT;
            r_keep    <= ONE_Q16;
            r_len     <= 7'd64;
            r_load    <= '0;
            r_rebuild <= 1'b0;
            r_valid   <= 1'b0;
            r_i       <= LW'(1);
            r_j       <= '0;
            r_phase   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EMIT);
            if (wr_keep) begin
                r_keep <= pwdata[16:0];
            end
            if (wr_len) begin
                r_len <= pwdata[6:0];
            end
            // a keep write schedules a rebuild; starting one clears it
            if (wr_keep) begin
                r_rebuild <= 1'b1;
            end else if (r_state == S_BUILD_INIT) begin
                r_rebuild <= 1'b0;
            end
            // load counter: a length write restarts the vector
            if (wr_len) begin
                r_load <= '0;
            end else if (accept) begin
                r_load <= (r_load >= CW'(eff_n1)) ? '0 : r_load + 1'b1;
            end
            case (r_state)
                S_BUILD_INIT: begin
                    r_i <= LW'(1); r_j <= '0; r_phase <= 1'b0;
                end
                S_BUILD_RD:   ;
                S_BUILD_WAIT: begin
                    if (!r_phase) r_a <= t_rdata;
                    else          r_b <= t_rdata;
                    r_phase <= ~r_phase;
                end
                S_BUILD_MUL2: begin r_acc <= 33'd0; r_prod <= mul; end
                S_BUILD_MUL1: begin r_acc <= {1'b0, r_prod[47:16]}; r_prod <= mul; end
                S_BUILD_WR: begin
                    if (r_j == r_i) begin r_i <= r_i + 1'b1; r_j <= '0; end
                    else r_j <= r_j + 1'b1;
                end
                S_IDLE: begin
                    if (accept && r_load >= CW'(eff_n1)) begin
                        r_n1  <= eff_n1;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_acc <= 33'd0;
                    end
                end
                S_MAC_MUL: r_prod <= mul;
                S_MAC_ACC: begin
                    r_acc <= sum_m[32] ? 33'h0_FFFF_FFFF : sum_m;
                    r_i   <= r_i + 1'b1;
                end
                S_EMIT: begin
                    r_out   <= r_acc[31:0];
                    r_last  <= (r_j == r_n1);
                    r_acc   <= 33'd0;
                    r_j     <= r_j + 1'b1;
                    r_i     <= r_j + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_out_value = r_out;
    assign o_out_last  = r_last;

    // no input is taken in a product read step or a table write step
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC_RD || r_state == S_BUILD_WR) |-> !accept)
        else $error("accept while busy");
    // a result strobe follows only an emit step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_EMIT)
        else $error("stray result");
    // last marker ends the vector
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |-> r_state == S_IDLE)
        else $error("last without return to idle");
endmodule

/* hdl/btm_ram.sv */
`timescale 1ns / 1ps
module btm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule
